FILE: hw/rtl/nine_slice_quad_clipper_unit_assert.svh
// assertion macros for the quad clipper
`ifndef NINE_SLICE_QUAD_CLIPPER_UNIT_ASSERT_SVH
`define NINE_SLICE_QUAD_CLIPPER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NSQC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define NSQC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define NSQC_ASSERT(lbl, prop, msg)
`define NSQC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/nsqc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nsqc_pkg;
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 20;
    localparam int DIV_QUO_W = 20;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_QUO_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_EDGE, S_MUL, S_DSTART, S_DWAIT, S_APPLY,
        S_AREA, S_SMUL, S_SSTORE, S_OUT
    } t_state;

    localparam logic [2:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [2:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [2:0] CFG_CLIP_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_CLIP_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_BB_SCALE    = 3'd4;
    localparam logic [2:0] CFG_TEX_READY   = 3'd5;

    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_TOP    = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;
endpackage
`default_nettype wire

FILE: hw/rtl/nsqc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module nsqc_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  nsqc_pkg::t_div_req  i_req,
    output nsqc_pkg::t_div_rsp  o_rsp
);
    localparam int NW = nsqc_pkg::DIV_NUM_W;
    localparam int DW = nsqc_pkg::DIV_DEN_W;
    localparam int QW = nsqc_pkg::DIV_QUO_W;
    localparam int CW = $clog2(QW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_shq, n_shq;
    logic [DW-1:0] r_den, n_den;
    logic [DW+1:0] w_trial;
    logic [DW:0]   w_shift;
    logic          w_ge;

    // quotient is known to fit QW bits, so the top of the dividend starts as remainder
    assign w_shift = {r_rem, r_shq[QW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge    = !w_trial[DW+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_shq  = r_shq;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(QW - 1);
            n_rem  = i_req.num[NW-1:QW];
            n_shq  = i_req.num[QW-1:0];
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = w_ge ? w_trial[DW-1:0] : w_shift[DW-1:0];
            n_shq = {r_shq[QW-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_shq <= n_shq;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_shq;
endmodule
`default_nettype wire

FILE: hw/rtl/nine_slice_quad_clipper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | payload
// s_axis    | in        | tuser: mode; tdata: request fields
// m_axis    | out       | tuser: visible; tlast: last quad; tdata: quad fields
// cfg       | in        | index 3 bit, data 20 bit, always ready
// one quad at a time through a shared 25x25 multiplier and a radix-2 divider;
// a drawn quad passes setup, the clip edge checks, area and scaling before its
// output; a rejected quad goes from setup straight to output; a request makes
// 1 or 9 quads; the 20 step divider dominates clipped quads.
// synchronous active-low reset returns to idle with default clip and scale.
// input ready only while idle; a quad waits in its output register for tready.
`include "nine_slice_quad_clipper_unit_assert.svh"
module nine_slice_quad_clipper_unit #(
    parameter int BAKE_FACTOR = 2,
    parameter int ATLAS_SIZE  = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // dst_x, dst_y, dst_w, dst_h, src_x, src_y, src_w, src_h, corner_cut, argb, pad
    input  wire  [167:0] i_s_axis_tdata,
    // mode
    input  wire          i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // out_x, out_y, out_w, out_h, tex_u0, tex_v0, tex_u1, tex_v1, colour, pad
    output logic [191:0] o_m_axis_tdata,
    // visible
    output logic         o_m_axis_tuser,
    output logic         o_m_axis_tlast,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [19:0]  i_cfg_data
);
    localparam int GW      = 24;
    localparam int TEX_LIM = ATLAS_SIZE * 256;
    localparam int TEX_MAX = (TEX_LIM > 524287) ? 524287 : TEX_LIM;
    // reciprocal of the bake factor, exact for corner sizes below 2^14
    localparam int CUT_RECIP = (262144 + BAKE_FACTOR - 1) / BAKE_FACTOR;

    nsqc_pkg::t_state r_state, n_state;

    // configuration
    logic [19:0] r_clip_left, r_clip_top;
    logic [18:0] r_clip_w, r_clip_h;
    logic [11:0] r_scale;
    logic        r_tex_ready;

    // held request
    logic        r_mode;
    logic [19:0] r_dx, r_dy, r_dw, r_dh;
    logic [10:0] r_sx, r_sy, r_sw, r_sh;
    logic [9:0]  r_ca;
    logic [31:0] r_argb;

    logic [1:0]  r_row, r_col, r_edge;
    logic [1:0]  r_sidx;
    logic signed [GW-1:0] r_x0, r_x1, r_y0, r_y1, r_w, r_h;
    logic signed [GW-1:0] r_u0, r_u1, r_v0, r_v1, r_du, r_dv;
    logic signed [49:0]   r_prod;
    logic        r_dneg;
    logic        r_vis;
    logic [19:0] r_ox, r_oy;
    logic [18:0] r_ow, r_oh, r_tu0, r_tv0, r_tu1, r_tv1;

    nsqc_pkg::t_div_req w_dreq;
    nsqc_pkg::t_div_rsp w_drsp;

    logic signed [GW-1:0] w_dx, w_dy, w_dw, w_dh, w_sx, w_sy, w_sw, w_sh, w_ca, w_cut;
    logic signed [GW-1:0] w_cx0, w_cx1, w_cy0, w_cy1;
    logic signed [GW-1:0] w_gx, w_gw, w_gy, w_gh, w_tx, w_tw, w_ty, w_th;
    logic signed [GW-1:0] w_ovh, w_d, w_den, w_q, w_sval;
    logic [19:0]          w_dabs;
    logic                 w_need, w_single, w_last, w_reject;
    logic signed [24:0]   w_ma, w_mb;
    logic signed [49:0]   w_mp, w_shr;
    logic [32:0]          w_cut_prod;

    assign w_dx  = {{4{r_dx[19]}}, r_dx};
    assign w_dy  = {{4{r_dy[19]}}, r_dy};
    assign w_dw  = {{4{r_dw[19]}}, r_dw};
    assign w_dh  = {{4{r_dh[19]}}, r_dh};
    assign w_sx  = {13'd0, r_sx};
    assign w_sy  = {13'd0, r_sy};
    assign w_sw  = {13'd0, r_sw};
    assign w_sh  = {13'd0, r_sh};
    assign w_ca  = {14'd0, r_ca};
    // corner size in design Q.4: corner_cut * 16 / bake factor, rounded down
    assign w_cut_prod = {19'd0, r_ca, 4'd0} * 33'(CUT_RECIP);
    assign w_cut      = {10'd0, w_cut_prod[31:18]};

    assign w_cx0 = {{4{r_clip_left[19]}}, r_clip_left};
    assign w_cy0 = {{4{r_clip_top[19]}}, r_clip_top};
    assign w_cx1 = w_cx0 + {5'd0, r_clip_w};
    assign w_cy1 = w_cy0 + {5'd0, r_clip_h};

    assign w_single = !r_mode || (w_dw <= (w_cut <<< 1)) || (w_dh <= (w_cut <<< 1));
    assign w_last   = w_single || (r_row == 2'd2 && r_col == 2'd2);

    // piece geometry for the current row and column
    always_comb begin
        w_gx = w_dx;
        w_gw = w_dw;
        w_tx = w_sx;
        w_tw = w_sw;
        w_gy = w_dy;
        w_gh = w_dh;
        w_ty = w_sy;
        w_th = w_sh;
        if (!w_single) begin
            case (r_col)
                2'd0: begin
                    w_gw = w_cut;
                    w_tw = w_ca;
                end
                2'd1: begin
                    w_gx = w_dx + w_cut;
                    w_gw = w_dw - (w_cut <<< 1);
                    w_tx = w_sx + w_ca;
                    w_tw = w_sw - (w_ca <<< 1);
                end
                default: begin
                    w_gx = w_dx + w_dw - w_cut;
                    w_gw = w_cut;
                    w_tx = w_sx + w_sw - w_ca;
                    w_tw = w_ca;
                end
            endcase
            case (r_row)
                2'd0: begin
                    w_gh = w_cut;
                    w_th = w_ca;
                end
                2'd1: begin
                    w_gy = w_dy + w_cut;
                    w_gh = w_dh - (w_cut <<< 1);
                    w_ty = w_sy + w_ca;
                    w_th = w_sh - (w_ca <<< 1);
                end
                default: begin
                    w_gy = w_dy + w_dh - w_cut;
                    w_gh = w_cut;
                    w_ty = w_sy + w_sh - w_ca;
                    w_th = w_ca;
                end
            endcase
        end
    end

    assign w_reject = !r_tex_ready || (w_gw <= 0) || (w_gh <= 0) || (r_argb[31:24] == 8'd0)
                   || (w_gx + w_gw <= w_cx0) || (w_gx >= w_cx1)
                   || (w_gy + w_gh <= w_cy0) || (w_gy >= w_cy1);

    always_comb begin
        case (r_edge)
            nsqc_pkg::EDGE_LEFT: begin
                w_need = r_x0 < w_cx0;
                w_ovh  = w_cx0 - r_x0;
                w_d    = r_du;
                w_den  = r_w;
            end
            nsqc_pkg::EDGE_TOP: begin
                w_need = r_y0 < w_cy0;
                w_ovh  = w_cy0 - r_y0;
                w_d    = r_dv;
                w_den  = r_h;
            end
            nsqc_pkg::EDGE_RIGHT: begin
                w_need = r_x1 > w_cx1;
                w_ovh  = r_x1 - w_cx1;
                w_d    = r_du;
                w_den  = r_w;
            end
            default: begin
                w_need = r_y1 > w_cy1;
                w_ovh  = r_y1 - w_cy1;
                w_d    = r_dv;
                w_den  = r_h;
            end
        endcase
    end

    assign w_dabs = w_d[GW-1] ? 20'(-w_d) : 20'(w_d);
    assign w_q    = r_dneg ? -{4'd0, w_drsp.quot} : {4'd0, w_drsp.quot};

    always_comb begin
        case (r_sidx)
            2'd0:    w_sval = r_x0;
            2'd1:    w_sval = r_y0;
            2'd2:    w_sval = r_x1 - r_x0;
            default: w_sval = r_y1 - r_y0;
        endcase
    end

    // shared multiplier: clip shift product or backbuffer scaling
    always_comb begin
        if (r_state == nsqc_pkg::S_MUL) begin
            w_ma = {w_ovh[GW-1], w_ovh};
            w_mb = {5'd0, w_dabs};
        end else begin
            w_ma = {w_sval[GW-1], w_sval};
            w_mb = {13'd0, r_scale};
        end
    end
    assign w_mp  = w_ma * w_mb;
    assign w_shr = r_prod >>> 8;

    assign w_dreq.start = (r_state == nsqc_pkg::S_DSTART);
    assign w_dreq.num   = r_prod[nsqc_pkg::DIV_NUM_W-1:0];
    assign w_dreq.den   = w_den[nsqc_pkg::DIV_DEN_W-1:0];

    nsqc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    function automatic logic [18:0] tex_sat(input logic signed [GW-1:0] v);
        logic [18:0] res;
        if (v < 0)
            res = '0;
        else if (v > GW'(TEX_MAX))
            res = 19'(TEX_MAX);
        else
            res = v[18:0];
        return res;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            nsqc_pkg::S_IDLE:   if (i_s_axis_tvalid) n_state = nsqc_pkg::S_SETUP;
            nsqc_pkg::S_SETUP:  n_state = w_reject ? nsqc_pkg::S_OUT : nsqc_pkg::S_EDGE;
            nsqc_pkg::S_EDGE: begin
                if (w_need)
                    n_state = nsqc_pkg::S_MUL;
                else if (r_edge == nsqc_pkg::EDGE_BOTTOM)
                    n_state = nsqc_pkg::S_AREA;
            end
            nsqc_pkg::S_MUL:    n_state = nsqc_pkg::S_DSTART;
            nsqc_pkg::S_DSTART: n_state = nsqc_pkg::S_DWAIT;
            nsqc_pkg::S_DWAIT:  if (w_drsp.done) n_state = nsqc_pkg::S_APPLY;
            nsqc_pkg::S_APPLY: begin
                n_state = (r_edge == nsqc_pkg::EDGE_BOTTOM) ? nsqc_pkg::S_AREA
                                                            : nsqc_pkg::S_EDGE;
            end
            nsqc_pkg::S_AREA: begin
                n_state = ((r_x1 - r_x0 <= 0) || (r_y1 - r_y0 <= 0)) ? nsqc_pkg::S_OUT
                                                                      : nsqc_pkg::S_SMUL;
            end
            nsqc_pkg::S_SMUL:   n_state = nsqc_pkg::S_SSTORE;
            nsqc_pkg::S_SSTORE: n_state = (r_sidx == 2'd3) ? nsqc_pkg::S_OUT : nsqc_pkg::S_SMUL;
            nsqc_pkg::S_OUT: begin
                if (i_m_axis_tready)
                    n_state = w_last ? nsqc_pkg::S_IDLE : nsqc_pkg::S_SETUP;
            end
            default:            n_state = nsqc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nsqc_pkg::S_IDLE;
            r_clip_left <= '0;
            r_clip_top  <= '0;
            r_clip_w    <= 19'd10240;
            r_clip_h    <= 19'd7680;
            r_scale     <= 12'd256;
            r_tex_ready <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_edge      <= '0;
            r_sidx      <= '0;
            r_vis       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    nsqc_pkg::CFG_CLIP_LEFT:   r_clip_left <= i_cfg_data;
                    nsqc_pkg::CFG_CLIP_TOP:    r_clip_top  <= i_cfg_data;
                    nsqc_pkg::CFG_CLIP_WIDTH:  r_clip_w    <= i_cfg_data[18:0];
                    nsqc_pkg::CFG_CLIP_HEIGHT: r_clip_h    <= i_cfg_data[18:0];
                    nsqc_pkg::CFG_BB_SCALE:    r_scale     <= i_cfg_data[11:0];
                    nsqc_pkg::CFG_TEX_READY:   r_tex_ready <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                nsqc_pkg::S_IDLE: begin
                    r_row <= '0;
                    r_col <= '0;
                end
                nsqc_pkg::S_SETUP: begin
                    r_edge <= nsqc_pkg::EDGE_LEFT;
                    r_vis  <= 1'b0;
                end
                nsqc_pkg::S_EDGE: if (!w_need) r_edge <= r_edge + 1'b1;
                nsqc_pkg::S_APPLY: r_edge <= r_edge + 1'b1;
                nsqc_pkg::S_AREA: r_sidx <= '0;
                nsqc_pkg::S_SSTORE: begin
                    r_sidx <= r_sidx + 1'b1;
                    if (r_sidx == 2'd3) r_vis <= 1'b1;
                end
                nsqc_pkg::S_OUT: begin
                    if (i_m_axis_tready && !w_last) begin
                        if (r_col == 2'd2) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (r_state == nsqc_pkg::S_IDLE && i_s_axis_tvalid) begin
            r_mode <= i_s_axis_tuser;
            r_dx   <= i_s_axis_tdata[19:0];
            r_dy   <= i_s_axis_tdata[39:20];
            r_dw   <= i_s_axis_tdata[59:40];
            r_dh   <= i_s_axis_tdata[79:60];
            r_sx   <= i_s_axis_tdata[90:80];
            r_sy   <= i_s_axis_tdata[101:91];
            r_sw   <= i_s_axis_tdata[112:102];
            r_sh   <= i_s_axis_tdata[123:113];
            r_ca   <= i_s_axis_tdata[133:124];
            r_argb <= i_s_axis_tdata[165:134];
        end

        case (r_state)
            nsqc_pkg::S_SETUP: begin
                r_x0 <= w_gx;
                r_x1 <= w_gx + w_gw;
                r_y0 <= w_gy;
                r_y1 <= w_gy + w_gh;
                r_w  <= w_gw;
                r_h  <= w_gh;
                r_u0 <= w_tx <<< 8;
                r_u1 <= (w_tx + w_tw) <<< 8;
                r_v0 <= w_ty <<< 8;
                r_v1 <= (w_ty + w_th) <<< 8;
                r_du <= w_tw <<< 8;
                r_dv <= w_th <<< 8;
                r_ox  <= '0;
                r_oy  <= '0;
                r_ow  <= '0;
                r_oh  <= '0;
                r_tu0 <= '0;
                r_tv0 <= '0;
                r_tu1 <= '0;
                r_tv1 <= '0;
            end
            nsqc_pkg::S_MUL: begin
                r_prod <= w_mp;
                r_dneg <= w_d[GW-1];
            end
            nsqc_pkg::S_APPLY: begin
                case (r_edge)
                    nsqc_pkg::EDGE_LEFT: begin
                        r_u0 <= r_u0 + w_q;
                        r_x0 <= w_cx0;
                    end
                    nsqc_pkg::EDGE_TOP: begin
                        r_v0 <= r_v0 + w_q;
                        r_y0 <= w_cy0;
                    end
                    nsqc_pkg::EDGE_RIGHT: begin
                        r_u1 <= r_u1 - w_q;
                        r_x1 <= w_cx1;
                    end
                    default: begin
                        r_v1 <= r_v1 - w_q;
                        r_y1 <= w_cy1;
                    end
                endcase
            end
            nsqc_pkg::S_AREA: begin
                if ((r_x1 - r_x0 > 0) && (r_y1 - r_y0 > 0)) begin
                    r_tu0 <= tex_sat(r_u0);
                    r_tv0 <= tex_sat(r_v0);
                    r_tu1 <= tex_sat(r_u1);
                    r_tv1 <= tex_sat(r_v1);
                end
            end
            nsqc_pkg::S_SMUL: r_prod <= w_mp;
            nsqc_pkg::S_SSTORE: begin
                case (r_sidx)
                    2'd0: begin
                        if (w_shr > 50'sd524287)       r_ox <= 20'h7FFFF;
                        else if (w_shr < -50'sd524288) r_ox <= 20'h80000;
                        else                           r_ox <= w_shr[19:0];
                    end
                    2'd1: begin
                        if (w_shr > 50'sd524287)       r_oy <= 20'h7FFFF;
                        else if (w_shr < -50'sd524288) r_oy <= 20'h80000;
                        else                           r_oy <= w_shr[19:0];
                    end
                    2'd2: begin
                        if (w_shr > 50'sd524287) r_ow <= 19'h7FFFF;
                        else if (w_shr < 0)      r_ow <= '0;
                        else                     r_ow <= w_shr[18:0];
                    end
                    default: begin
                        if (w_shr > 50'sd524287) r_oh <= 19'h7FFFF;
                        else if (w_shr < 0)      r_oh <= '0;
                        else                     r_oh <= w_shr[18:0];
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == nsqc_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = (r_state == nsqc_pkg::S_OUT);
    assign o_m_axis_tuser  = r_vis;
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tdata  = {6'd0, r_argb, r_tv1, r_tu1, r_tv0, r_tu0, r_oh, r_ow, r_oy, r_ox};

    `NSQC_ASSERT(a_no_overlap, o_s_axis_tready |-> !o_m_axis_tvalid, "input ready while quad pending")
    `NSQC_ASSERT(a_accept_gap, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_m_axis_tvalid, "quad straight after transaction")
    `NSQC_ASSERT(a_hidden_zero, (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[153:0] == '0), "hidden quad carries geometry")
    `NSQC_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")
endmodule
`default_nettype wire
